>>> src/pfr_pkg.sv
// Shared constants, types and tables of the potential field repulsion unit.
package pfr_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int CNT_W       = 11;
    localparam int VAL_W       = 16;
    localparam int NUM_W       = 56;
    localparam int DEN_W       = 32;
    localparam int ROOT_W      = 28;
    localparam int SUM_W       = 40;
    localparam int MAG_W       = 15;
    localparam int CRD_W       = 32;
    localparam int ANG_W       = 18;
    localparam int CRD_STEPS   = 14;
    localparam int CRD_CNT_W   = 4;

    localparam logic [15:0] CORDIC_SCALE = 16'd39797;
    localparam logic [15:0] CUTOFF_RST   = 16'd819;
    localparam logic [15:0] GAIN_RST     = 16'd1280;
    localparam logic [MAG_W-1:0] MAG_MAX = 15'h7FFF;

    typedef enum logic [1:0] {
        CFG_START_ANGLE = 2'd0,
        CFG_ANGLE_STEP  = 2'd1,
        CFG_CUTOFF      = 2'd2,
        CFG_GAIN        = 2'd3
    } cfg_index_t;

    typedef logic signed [VAL_W-1:0] q88_t;

    function automatic logic signed [ANG_W-1:0] atan_lookup(input logic [CRD_CNT_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/pfr_if.sv
// Valid/ready channel interfaces for scan samples and force results.
interface pfr_in_if;
    logic              valid;
    logic              ready;
    logic [15:0]       range;
    logic signed [15:0] heading;
    logic              last;

    modport source (output valid, output range, output heading, output last, input ready);
    modport sink (input valid, input range, input heading, input last, output ready);
endinterface

interface pfr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] force_x;
    logic signed [15:0] force_y;
    logic [10:0]        sample_count;
    logic               saturated;

    modport source (output valid, output force_x, output force_y, output sample_count,
                    output saturated, input ready);
    modport sink (input valid, input force_x, input force_y, input sample_count,
                  input saturated, output ready);
endinterface

>>> src/pfr_div.sv
// Shared restoring divider, one quotient bit per cycle.
module pfr_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pfr_pkg::NUM_W-1:0] dividend,
    input  logic [pfr_pkg::DEN_W-1:0] divisor,
    output logic                      done,
    output logic [pfr_pkg::NUM_W-1:0] quotient
);

    logic [pfr_pkg::NUM_W-1:0] quo_reg, quo_next;
    logic [pfr_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [pfr_pkg::DEN_W-1:0] dvs_reg;
    logic [5:0]                cnt_reg, cnt_next;
    logic                      run_reg, run_next;
    logic                      done_reg, done_next;
    logic [pfr_pkg::DEN_W:0]   trial;
    logic [pfr_pkg::DEN_W:0]   diff;

    assign trial = {rem_reg, quo_reg[pfr_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[pfr_pkg::DEN_W])
            begin
                rem_next = diff[pfr_pkg::DEN_W-1:0];
                quo_next = {quo_reg[pfr_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[pfr_pkg::DEN_W-1:0];
                quo_next = {quo_reg[pfr_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(pfr_pkg::NUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> src/pfr_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module pfr_isqrt
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pfr_pkg::NUM_W-1:0]  value,
    output logic                       done,
    output logic [pfr_pkg::ROOT_W-1:0] root
);

    logic [pfr_pkg::NUM_W-1:0] v_reg, v_next;
    logic [pfr_pkg::NUM_W-1:0] res_reg, res_next;
    logic [pfr_pkg::NUM_W-1:0] bit_reg, bit_next;
    logic [4:0]                cnt_reg, cnt_next;
    logic                      run_reg, run_next;
    logic                      done_reg, done_next;
    logic [pfr_pkg::NUM_W-1:0] sum;

    assign sum = res_reg + bit_reg;

    always_comb
    begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next   = value;
            res_next = '0;
            bit_next = {2'b01, {(pfr_pkg::NUM_W-2){1'b0}}};
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (v_reg >= sum)
            begin
                v_next   = v_reg - sum;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(pfr_pkg::ROOT_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[pfr_pkg::ROOT_W-1:0];

endmodule

>>> src/pfr_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle, with half-turn folding.
module pfr_cordic
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pfr_pkg::MAG_W-1:0]       mag,
    input  logic [15:0]                     angle,
    output logic                            done,
    output logic signed [pfr_pkg::CRD_W-1:0] x_out,
    output logic signed [pfr_pkg::CRD_W-1:0] y_out
);

    logic signed [pfr_pkg::CRD_W-1:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [pfr_pkg::ANG_W-1:0] z_reg, z_next, z_in;
    logic [pfr_pkg::CRD_CNT_W-1:0]    i_reg, i_next;
    logic                             flip_reg, flip_next;
    logic                             run_reg, run_next;
    logic                             done_reg, done_next;
    logic [30:0]                      scaled;

    assign z_in   = {{(pfr_pkg::ANG_W-16){angle[15]}}, angle};
    assign scaled = 31'(mag) * 31'(pfr_pkg::CORDIC_SCALE);
    assign dx     = y_reg >>> i_reg;
    assign dy     = x_reg >>> i_reg;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        flip_next = flip_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = pfr_pkg::CRD_W'(scaled >> 2);
            y_next    = '0;
            i_next    = '0;
            run_next  = 1'b1;
            flip_next = 1'b0;
            z_next    = z_in;
            if (z_in > 18'sd16384)
            begin
                z_next    = z_in - 18'sd32768;
                flip_next = 1'b1;
            end
            else if (z_in < -18'sd16384)
            begin
                z_next    = z_in + 18'sd32768;
                flip_next = 1'b1;
            end
        end
        else if (run_reg)
        begin
            if (!z_reg[pfr_pkg::ANG_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - pfr_pkg::atan_lookup(i_reg);
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + pfr_pkg::atan_lookup(i_reg);
            end
            i_next = i_reg + 4'd1;
            if (i_reg == 4'(pfr_pkg::CRD_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign done  = done_reg;
    assign x_out = flip_reg ? -x_reg : x_reg;
    assign y_out = flip_reg ? -y_reg : y_reg;

endmodule

>>> src/potential_field_repulsion_unit.sv
// Top level: repulsive force of a potential field accumulated over one laser scan.
//
// Channels: "samples" carries one range sample per beat (range, heading,
// last); "results" carries one beat per scan (force_x, force_y,
// sample_count, saturated), produced on the sample marked last.
// Configuration: cfg_we with cfg_index/cfg_wdata writes start_angle,
// angle_step, cutoff_range and gain; write only while the block is idle.
// A sample within range passes through the divide, the square root and
// the CORDIC rotation, plus sequencing; a sample at or beyond the cutoff,
// or at zero range, skips the divide and the square root. The last sample
// of a scan adds two divides for the means. samples.ready is high only in
// the idle state, so one sample is in work at a time; the shared divider
// sets the pace.
// Reset clears the sums, the sample counter, the clamp flag and the
// output valid flag, and loads the register defaults.
// A stalled receiver holds the result in the output register; the block
// keeps taking samples and waits only when the next scan result is ready.
module potential_field_repulsion_unit
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_wdata,
    pfr_in_if.sink           samples,
    pfr_out_if.source        results
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_PREP = 9'b000000010,
        ST_DIV  = 9'b000000100,
        ST_SQRT = 9'b000001000,
        ST_MAG  = 9'b000010000,
        ST_CST  = 9'b000100000,
        ST_ROT  = 9'b001000000,
        ST_FIN  = 9'b010000000,
        ST_FDX  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   fdy_reg, fdy_next;
    logic   out_pend_reg, out_pend_next;

    logic [15:0] start_angle_reg, angle_step_reg, cutoff_reg, gain_reg;

    logic signed [pfr_pkg::SUM_W-1:0] sum_x_reg, sum_y_reg, sum_x_next, sum_y_next;
    logic [pfr_pkg::CNT_W-1:0]        idx_reg, idx_next;
    logic                             clamp_reg, clamp_next;

    logic [15:0]                 range_reg, angle_reg;
    logic                        last_reg;
    logic [pfr_pkg::DEN_W-1:0]   den_reg;
    logic [pfr_pkg::MAG_W-1:0]   mag_reg, mag_next;
    logic                        mag_ld;
    pfr_pkg::q88_t               fx_reg, fx_next;
    logic                        fsat_reg, fsat_next;
    pfr_pkg::q88_t               fq_hold_y;

    logic          out_valid_reg, out_valid_next;
    pfr_pkg::q88_t out_fx_reg, out_fy_reg;
    logic [10:0]   out_cnt_reg;
    logic          out_sat_reg;
    logic          out_ld;

    logic                       div_start, div_done;
    logic [pfr_pkg::NUM_W-1:0]  div_dividend, div_quo;
    logic [pfr_pkg::DEN_W-1:0]  div_divisor;
    logic                       sq_start, sq_done;
    logic [pfr_pkg::ROOT_W-1:0] sq_root;
    logic                       crd_start, crd_done;
    logic signed [pfr_pkg::CRD_W-1:0] crd_x, crd_y;

    logic                       accept;
    logic [15:0]                angle_calc;
    logic [15:0]                diff_rc;
    logic [pfr_pkg::SUM_W-1:0]  abs_x, abs_y;
    logic [pfr_pkg::CNT_W-1:0]  n_div;
    logic [43:0]                mag_prod;
    logic [28:0]                mag_raw;
    logic signed [pfr_pkg::CRD_W+1:0] rx, ry;
    logic signed [pfr_pkg::SUM_W-1:0] cx, cy;
    pfr_pkg::q88_t              fq;
    logic                       fq_sat;
    logic                       fq_neg;

    assign accept     = samples.valid && samples.ready;
    assign angle_calc = start_angle_reg + 16'(idx_reg * angle_step_reg) + samples.heading;
    assign diff_rc    = cutoff_reg - range_reg;
    assign abs_x      = sum_x_reg[pfr_pkg::SUM_W-1] ? 40'(-sum_x_reg) : 40'(sum_x_reg);
    assign abs_y      = sum_y_reg[pfr_pkg::SUM_W-1] ? 40'(-sum_y_reg) : 40'(sum_y_reg);
    assign n_div      = (idx_reg == '0) ? 11'd1 : idx_reg;
    assign mag_prod   = 44'(gain_reg) * 44'(sq_root);
    assign mag_raw    = mag_prod[43:15];
    assign rx         = (pfr_pkg::CRD_W+2)'(8192) - (pfr_pkg::CRD_W+2)'(crd_x);
    assign ry         = (pfr_pkg::CRD_W+2)'(8192) - (pfr_pkg::CRD_W+2)'(crd_y);
    assign cx         = pfr_pkg::SUM_W'(rx >>> 14);
    assign cy         = pfr_pkg::SUM_W'(ry >>> 14);

    assign samples.ready = (state_reg == ST_IDLE) && !out_pend_reg;

    always_comb
    begin
        fq_neg = fdy_reg ? sum_y_reg[pfr_pkg::SUM_W-1] : sum_x_reg[pfr_pkg::SUM_W-1];
        fq_sat = 1'b0;
        if (!fq_neg)
        begin
            if (div_quo > 56'd32767)
            begin
                fq     = 16'sh7FFF;
                fq_sat = 1'b1;
            end
            else
            begin
                fq = div_quo[15:0];
            end
        end
        else
        begin
            if (div_quo > 56'd32768)
            begin
                fq     = 16'sh8000;
                fq_sat = 1'b1;
            end
            else
            begin
                fq = -div_quo[15:0];
            end
        end
    end

    always_comb
    begin
        div_dividend = {diff_rc, 40'b0};
        div_divisor  = den_reg;
        case (state_reg)
            ST_FIN:
            begin
                div_dividend = 56'(abs_x);
                div_divisor  = 32'(n_div);
            end
            ST_FDX:
            begin
                div_dividend = 56'(abs_y);
                div_divisor  = 32'(n_div);
            end
            default:
            begin
                div_dividend = {diff_rc, 40'b0};
                div_divisor  = den_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        fdy_next       = fdy_reg;
        out_pend_next  = out_pend_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        idx_next       = idx_reg;
        clamp_next     = clamp_reg;
        mag_next       = mag_reg;
        mag_ld         = 1'b0;
        fx_next        = fx_reg;
        fsat_next      = fsat_reg;
        out_valid_next = out_valid_reg;
        out_ld         = 1'b0;
        div_start      = 1'b0;
        sq_start       = 1'b0;
        crd_start      = 1'b0;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (out_pend_reg)
                begin
                    if (!out_valid_reg || results.ready)
                    begin
                        out_ld         = 1'b1;
                        out_valid_next = 1'b1;
                        out_pend_next  = 1'b0;
                        sum_x_next     = '0;
                        sum_y_next     = '0;
                        idx_next       = '0;
                        clamp_next     = 1'b0;
                    end
                end
                else if (accept)
                begin
                    if (idx_reg >= 11'(pfr_pkg::MAX_SAMPLES))
                    begin
                        clamp_next = 1'b1;
                        if (samples.last)
                        begin
                            state_next = ST_FIN;
                        end
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                if (range_reg >= cutoff_reg)
                begin
                    mag_next   = '0;
                    mag_ld     = 1'b1;
                    state_next = ST_CST;
                end
                else if (range_reg == '0)
                begin
                    mag_next   = pfr_pkg::MAG_MAX;
                    mag_ld     = 1'b1;
                    clamp_next = 1'b1;
                    state_next = ST_CST;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    sq_start   = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sq_done)
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                mag_ld = 1'b1;
                if (mag_raw > 29'(pfr_pkg::MAG_MAX))
                begin
                    mag_next   = pfr_pkg::MAG_MAX;
                    clamp_next = 1'b1;
                end
                else
                begin
                    mag_next = mag_raw[pfr_pkg::MAG_W-1:0];
                end
                state_next = ST_CST;
            end
            ST_CST:
            begin
                crd_start  = 1'b1;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                if (crd_done)
                begin
                    sum_x_next = sum_x_reg + cx;
                    sum_y_next = sum_y_reg + cy;
                    idx_next   = idx_reg + 11'd1;
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN:
            begin
                div_start  = 1'b1;
                fdy_next   = 1'b0;
                state_next = ST_FDX;
            end
            ST_FDX:
            begin
                if (div_done)
                begin
                    if (!fdy_reg)
                    begin
                        fx_next   = fq;
                        fsat_next = fq_sat;
                        fdy_next  = 1'b1;
                        div_start = 1'b1;
                    end
                    else
                    begin
                        fsat_next     = fsat_reg || fq_sat;
                        fdy_next      = 1'b0;
                        out_pend_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fdy_reg         <= 1'b0;
            out_pend_reg    <= 1'b0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            idx_reg         <= '0;
            clamp_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            start_angle_reg <= '0;
            angle_step_reg  <= '0;
            cutoff_reg      <= pfr_pkg::CUTOFF_RST;
            gain_reg        <= pfr_pkg::GAIN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            fdy_reg       <= fdy_next;
            out_pend_reg  <= out_pend_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            idx_reg       <= idx_next;
            clamp_reg     <= clamp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (pfr_pkg::cfg_index_t'(cfg_index))
                    pfr_pkg::CFG_START_ANGLE: start_angle_reg <= cfg_wdata;
                    pfr_pkg::CFG_ANGLE_STEP:  angle_step_reg  <= cfg_wdata;
                    pfr_pkg::CFG_CUTOFF:      cutoff_reg      <= cfg_wdata;
                    pfr_pkg::CFG_GAIN:        gain_reg        <= cfg_wdata;
                    default:                  gain_reg        <= gain_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            range_reg <= samples.range;
            last_reg  <= samples.last;
            angle_reg <= angle_calc;
            den_reg   <= 32'(samples.range) * 32'(cutoff_reg);
        end
        if (mag_ld)
        begin
            mag_reg <= mag_next;
        end
        fx_reg   <= fx_next;
        fsat_reg <= fsat_next;
        if (out_ld)
        begin
            out_fx_reg  <= fx_reg;
            out_fy_reg  <= fq_hold_y;
            out_cnt_reg <= idx_reg;
            out_sat_reg <= clamp_reg || fsat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FDX) && div_done && fdy_reg)
        begin
            fq_hold_y <= fq;
        end
    end

    pfr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    pfr_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (div_quo),
        .done  (sq_done),
        .root  (sq_root)
    );

    pfr_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (crd_start),
        .mag   (mag_reg),
        .angle (angle_reg),
        .done  (crd_done),
        .x_out (crd_x),
        .y_out (crd_y)
    );

    assign results.valid        = out_valid_reg;
    assign results.force_x      = out_fx_reg;
    assign results.force_y      = out_fy_reg;
    assign results.sample_count = out_cnt_reg;
    assign results.saturated    = out_sat_reg;

endmodule
